[src/mbm_pkg.sv]
// Shared types and codes for the Mandelbrot membership test block.
`default_nettype none
package mbm_pkg;

  localparam logic [1:0] VERD_OUT       = 2'd0;
  localparam logic [1:0] VERD_IN        = 2'd1;
  localparam logic [1:0] VERD_UNDECIDED = 2'd2;

  localparam logic [1:0] CFG_DWELL  = 2'd0;
  localparam logic [1:0] CFG_SETTLE = 2'd1;
  localparam logic [1:0] CFG_ORBIT  = 2'd2;

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_BULB,
    KIND_CARD,
    KIND_PLAIN
  } kind_t;

  typedef struct packed {
    logic signed [63:0] re;
    logic signed [63:0] im;
    kind_t              kind;
  } item_t;

  typedef struct packed {
    logic [23:0] dwell;
    logic [60:0] settle;
    logic [60:0] orbit;
  } cfg_t;

endpackage
`default_nettype wire

[src/mbm_front.sv]
// Front end: box filter and region classification of incoming points.
`default_nettype none
module mbm_front import mbm_pkg::*; #(
  parameter int FRAC_BITS = 60
) (
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] point_re,
  input  logic signed [63:0] point_im,
  input  logic               q_full,
  output logic               q_wr,
  output item_t              q_item
);

  localparam logic [127:0] ONE = 128'd1 << FRAC_BITS;
  localparam logic signed [63:0] K115  = 64'((ONE * 128'd230 + 128'd100) / 128'd200);
  localparam logic signed [63:0] K049  = 64'((ONE * 128'd98 + 128'd100) / 128'd200);
  localparam logic signed [63:0] K2    = 64'(ONE * 128'd2);
  localparam logic signed [63:0] K125  = 64'((ONE * 128'd250 + 128'd100) / 128'd200);
  localparam logic signed [63:0] K075  = 64'((ONE * 128'd150 + 128'd100) / 128'd200);
  localparam logic signed [63:0] K0375 = 64'((ONE * 128'd750 + 128'd1000) / 128'd2000);
  localparam logic signed [63:0] K065  = 64'((ONE * 128'd130 + 128'd100) / 128'd200);
  localparam logic signed [63:0] K025  = 64'((ONE * 128'd50 + 128'd100) / 128'd200);

  logic reject, bulb, card;

  assign reject = (point_im < -K115) || (point_im > K115) ||
                  (point_re < -K2) || (point_re > K049);
  assign bulb   = (point_re > -K125) && (point_re < -K075) && (point_im < K025);
  assign card   = (point_re > -K075) && (point_re < K0375) && (point_im < K065);

  always_comb begin
    q_item.re = point_re;
    q_item.im = point_im;
    if (reject) begin
      q_item.kind = KIND_REJECT;
    end else if (bulb) begin
      q_item.kind = KIND_BULB;
    end else if (card) begin
      q_item.kind = KIND_CARD;
    end else begin
      q_item.kind = KIND_PLAIN;
    end
  end

  assign full = q_full;
  assign q_wr = push && !q_full;

endmodule
`default_nettype wire

[src/mbm_fifo.sv]
// Two-entry queue of classified points between front and back end.
`default_nettype none
module mbm_fifo import mbm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  empty
);

  item_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule
`default_nettype wire

[src/mbm_mul.sv]
// Shared fixed-point multiplier: four 32x32 partials, then sign, shift and range check.
`default_nettype none
module mbm_mul #(
  parameter int FRAC_BITS = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        half,
  output logic        done,
  output logic [63:0] res,
  output logic        ovf
);

  logic [63:0]         ma, mb;
  logic                neg, half_r, busy;
  logic [127:0]        acc;
  logic [2:0]          cnt;
  logic [31:0]         pa, pb;
  logic [63:0]         pp;
  logic [127:0]        pp_sh;
  logic signed [127:0] sp, sh;

  always_comb begin
    pa = cnt[0] ? ma[63:32] : ma[31:0];
    pb = cnt[1] ? mb[63:32] : mb[31:0];
    pp = pa * pb;
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    sp = neg ? $signed(128'd0 - acc) : $signed(acc);
    sh = half_r ? (sp >>> (FRAC_BITS - 1)) : (sp >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma     <= a[63] ? 64'd0 - a : a;
        mb     <= b[63] ? 64'd0 - b : b;
        neg    <= a[63] ^ b[63];
        half_r <= half;
        acc    <= 128'd0;
        cnt    <= 3'd0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end else begin
          res  <= sh[63:0];
          ovf  <= !((sh[127:63] == '0) || (sh[127:63] == '1));
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/mbm_back.sv]
// Back end: disc and region tests, escape-time iteration and result register.
`default_nettype none
module mbm_back import mbm_pkg::*; #(
  parameter int FRAC_BITS  = 60,
  parameter int DWELL_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  output logic        q_rd,
  input  item_t       q_item,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  verdict
);

  localparam logic [127:0] ONE = 128'd1 << FRAC_BITS;
  localparam logic signed [63:0] K4    = 64'(ONE * 128'd4);
  localparam logic [63:0]        K1    = 64'(ONE);
  localparam logic [63:0]        K0625 = 64'((ONE * 128'd1250 + 128'd10000) / 128'd20000);
  localparam logic [63:0]        K025  = 64'((ONE * 128'd50 + 128'd100) / 128'd200);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DISC   = 9'b000000010,
    ST_BULB   = 9'b000000100,
    ST_CARD_Q = 9'b000001000,
    ST_CARD_V = 9'b000010000,
    ST_ITER   = 9'b000100000,
    ST_ESC    = 9'b001000000,
    ST_TORT   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  function automatic logic [64:0] fx_add(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    r = x + y;
    return {(x[63] == y[63]) && (r[63] != x[63]), r};
  endfunction

  function automatic logic [64:0] fx_sub(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    r = x - y;
    return {(x[63] != y[63]) && (r[63] != x[63]), r};
  endfunction

  function automatic logic [63:0] fx_dist(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] d;
    d = {x[63], x} - {y[63], y};
    return d[64] ? 64'(65'd0 - d) : d[63:0];
  endfunction

  state_t          state;
  kind_t           kind;
  logic [63:0]     cre, cim, zre, zim, pre, pim, tre, tim, qv, tv;
  logic [63:0]     p0, p1, p2;
  logic            mov, wait_mul;
  logic [1:0]      idx, nprod;
  logic [DWELL_BITS-1:0] i, lim;
  logic [2:0]      m5;
  logic [1:0]      verd;
  logic            res_valid;
  logic [1:0]      res_verdict;

  logic        mul_start, mul_done, mul_ovf, mul_half;
  logic [63:0] mul_a, mul_b, mul_res;
  logic [31:0] dwell_ext;
  logic [64:0] s01, d01, vb, tc, nre, nim;
  logic        at_combine, last_iter;
  logic [63:0] st_thr, ot_thr;
  logic        settled, orbit_hit;

  assign dwell_ext = 32'(cfg.dwell);
  assign lim       = dwell_ext[DWELL_BITS-1:0];
  assign st_thr    = {3'd0, cfg.settle};
  assign ot_thr    = {3'd0, cfg.orbit};

  always_comb begin
    nprod    = 2'd2;
    mul_a    = zre;
    mul_b    = zre;
    mul_half = 1'b0;
    case (state)
      ST_DISC: begin
        mul_a = idx[0] ? cim : cre;
        mul_b = mul_a;
      end
      ST_BULB: begin
        mul_a = idx[0] ? cim : cre + K1;
        mul_b = mul_a;
      end
      ST_CARD_Q: begin
        nprod    = 2'd3;
        mul_a    = (idx == 2'd1) ? cim : cre - K025;
        mul_b    = (idx == 2'd2) ? K025 : mul_a;
        mul_half = idx == 2'd2;
      end
      ST_CARD_V: begin
        mul_a = idx[0] ? K025 : tv;
        mul_b = idx[0] ? qv : tv;
      end
      ST_ITER, ST_ESC: begin
        nprod    = (state == ST_ITER) ? 2'd3 : 2'd2;
        mul_a    = (idx == 2'd1) ? zim : zre;
        mul_b    = (idx == 2'd0) ? zre : zim;
        mul_half = idx == 2'd2;
      end
      ST_TORT: begin
        nprod    = 2'd3;
        mul_a    = (idx == 2'd1) ? tim : tre;
        mul_b    = (idx == 2'd0) ? tre : tim;
        mul_half = idx == 2'd2;
      end
      default: begin
        nprod = 2'd0;
      end
    endcase
  end

  assign at_combine = idx == nprod;
  assign mul_start  = !(state == ST_IDLE || state == ST_DONE) && !at_combine && !wait_mul;

  assign s01       = fx_add(p0, p1);
  assign d01       = fx_sub(p0, p1);
  assign vb        = fx_sub(s01[63:0], K0625);
  assign tc        = fx_add(s01[63:0], p2);
  assign nre       = fx_add(d01[63:0], cre);
  assign nim       = fx_add(p2, cim);
  assign last_iter = (i + DWELL_BITS'(1)) == lim;
  assign settled   = (fx_dist(pre, zre) < st_thr) && (fx_dist(pim, zim) < st_thr);
  assign orbit_hit = (fx_dist(nre[63:0], zre) < ot_thr) &&
                     (fx_dist(nim[63:0], zim) < ot_thr);

  assign q_rd    = (state == ST_IDLE) && !q_empty;
  assign empty   = !res_valid;
  assign verdict = res_verdict;

  mbm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .half  (mul_half),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wait_mul  <= 1'b0;
      idx       <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (mul_start) begin
        wait_mul <= 1'b1;
      end
      if (mul_done) begin
        case (idx)
          2'd0:    p0 <= mul_res;
          2'd1:    p1 <= mul_res;
          default: p2 <= mul_res;
        endcase
        mov      <= mov | mul_ovf;
        wait_mul <= 1'b0;
        idx      <= idx + 2'd1;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cre  <= q_item.re;
            cim  <= q_item.im;
            zre  <= q_item.re;
            zim  <= q_item.im;
            tre  <= q_item.re;
            tim  <= q_item.im;
            kind <= q_item.kind;
            i    <= '0;
            m5   <= 3'd0;
            mov  <= 1'b0;
            idx  <= 2'd0;
            if (q_item.kind == KIND_REJECT) begin
              verd  <= VERD_OUT;
              state <= ST_DONE;
            end else begin
              state <= ST_DISC;
            end
          end
        end
        ST_DONE: begin
          if (!res_valid) begin
            res_valid   <= 1'b1;
            res_verdict <= verd;
            state       <= ST_IDLE;
          end
        end
        default: begin
          if (at_combine) begin
            idx <= 2'd0;
            case (state)
              ST_DISC: begin
                if (mov || s01[64] || ($signed(s01[63:0]) > K4)) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else if (kind == KIND_BULB) begin
                  state <= ST_BULB;
                end else if (kind == KIND_CARD) begin
                  state <= ST_CARD_Q;
                end else if (lim == '0) begin
                  verd  <= VERD_UNDECIDED;
                  state <= ST_DONE;
                end else begin
                  state <= ST_ITER;
                end
              end
              ST_BULB, ST_CARD_V: begin
                if (mov || (state == ST_BULB ? (s01[64] || vb[64]) : d01[64])) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else if (state == ST_BULB ? vb[63] : d01[63]) begin
                  verd  <= VERD_IN;
                  state <= ST_DONE;
                end else if (lim == '0) begin
                  verd  <= VERD_UNDECIDED;
                  state <= ST_DONE;
                end else begin
                  state <= ST_ITER;
                end
              end
              ST_CARD_Q: begin
                qv <= s01[63:0];
                tv <= tc[63:0];
                if (mov || s01[64] || tc[64]) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else begin
                  state <= ST_CARD_V;
                end
              end
              ST_ITER: begin
                pre <= zre;
                pim <= zim;
                zre <= nre[63:0];
                zim <= nim[63:0];
                if (mov || d01[64] || nre[64] || nim[64]) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else if (m5 == 3'd1) begin
                  state <= ST_ESC;
                end else if (i[0]) begin
                  state <= ST_TORT;
                end else begin
                  i     <= i + DWELL_BITS'(1);
                  m5    <= (m5 == 3'd4) ? 3'd0 : m5 + 3'd1;
                  if (last_iter) begin
                    verd  <= VERD_UNDECIDED;
                    state <= ST_DONE;
                  end
                end
              end
              ST_ESC: begin
                if (mov || s01[64] || ($signed(s01[63:0]) > K4)) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else if (settled) begin
                  verd  <= VERD_IN;
                  state <= ST_DONE;
                end else if (i[0]) begin
                  state <= ST_TORT;
                end else begin
                  i  <= i + DWELL_BITS'(1);
                  m5 <= (m5 == 3'd4) ? 3'd0 : m5 + 3'd1;
                  if (last_iter) begin
                    verd  <= VERD_UNDECIDED;
                    state <= ST_DONE;
                  end else begin
                    state <= ST_ITER;
                  end
                end
              end
              ST_TORT: begin
                tre <= nre[63:0];
                tim <= nim[63:0];
                if (mov || d01[64] || nre[64] || nim[64]) begin
                  verd  <= VERD_OUT;
                  state <= ST_DONE;
                end else if (orbit_hit) begin
                  verd  <= VERD_IN;
                  state <= ST_DONE;
                end else begin
                  i  <= i + DWELL_BITS'(1);
                  m5 <= (m5 == 3'd4) ? 3'd0 : m5 + 3'd1;
                  if (last_iter) begin
                    verd  <= VERD_UNDECIDED;
                    state <= ST_DONE;
                  end else begin
                    state <= ST_ITER;
                  end
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[src/mandelbrot_membership_test.sv]
// Top level of the Mandelbrot membership test: config registers, front, queue, back.
//
//   channel  | handshake            | payload
//   input    | push / full          | point_re, point_im
//   result   | empty / pop          | verdict
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every multiply goes through the shared 32x32 multiplier, one product at a time;
// escape-check iterations and odd iterations each add a further round of products.
// The queue takes up to two points while the back end works; reset is
// synchronous and empties queue and result register. Config is always ready.
`default_nettype none
module mandelbrot_membership_test import mbm_pkg::*; #(
  parameter int FRAC_BITS  = 60,
  parameter int DWELL_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] point_re,
  input  logic signed [63:0] point_im,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         verdict,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  cfg_t  cfg;
  logic  q_wr, q_full, q_rd, q_empty;
  item_t q_wr_item, q_rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell  <= 24'd1024;
      cfg.settle <= 61'd1153;
      cfg.orbit  <= 61'd1153;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DWELL:  cfg.dwell  <= cfg_data[23:0];
        CFG_SETTLE: cfg.settle <= cfg_data[60:0];
        CFG_ORBIT:  cfg.orbit  <= cfg_data[60:0];
        default: ;
      endcase
    end
  end

  mbm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .push     (push),
    .full     (full),
    .point_re (point_re),
    .point_im (point_im),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_item   (q_wr_item)
  );

  mbm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  mbm_back #(.FRAC_BITS(FRAC_BITS), .DWELL_BITS(DWELL_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .q_item  (q_rd_item),
    .pop     (pop),
    .empty   (empty),
    .verdict (verdict)
  );

endmodule
`default_nettype wire

[src/mbm_checker.sv]
// Port-level checks for the Mandelbrot membership test, bound to the top level.
`default_nettype none
module mbm_checker import mbm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [1:0]  verdict,
  input logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (verdict == VERD_OUT || verdict == VERD_IN || verdict == VERD_UNDECIDED))
    else $error("bad verdict code");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(verdict)))
    else $error("result changed before pop");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && !push) |=> (empty && !full))
    else $error("result or full without input after reset");

endmodule

bind mandelbrot_membership_test mbm_checker u_mbm_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .verdict   (verdict),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

[tb/testbench.sv]
// Testbench for mandelbrot_membership_test: directed and random points checked against a predictor.
`timescale 1ns / 100ps
module testbench import mbm_pkg::*;;

  localparam int FB = 60;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [63:0] point_re = '0;
  logic signed [63:0] point_im = '0;
  logic               pop = 1'b0;
  logic               empty;
  logic [1:0]         verdict;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_DWELL;
  logic [63:0]        cfg_data = '0;

  mandelbrot_membership_test u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .point_re(point_re), .point_im(point_im),
    .pop(pop), .empty(empty), .verdict(verdict),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers
  logic [23:0] m_dwell  = 24'd1024;
  logic [60:0] m_settle = 61'd1153;
  logic [60:0] m_orbit  = 61'd1153;
  bit          ovf;

  logic [1:0] verdict_q[$];
  int         errors = 0;
  int         n_items = 0;
  int         n_out = 0, n_in = 0, n_und = 0;
  bit         no_idle = 1'b0;
  bit         stall_go = 1'b0;
  int         hold_left = 0;
  int         rx_roll;

  function automatic logic signed [63:0] kfx(longint unsigned num, longint unsigned den);
    logic [127:0] n;
    n = (128'(num) << (FB + 1)) + 128'(den);
    return 64'(n / (128'(den) * 2));
  endfunction

  function automatic logic signed [63:0] clip(logic signed [127:0] v);
    if (!(&v[127:63]) && (|v[127:63])) ovf = 1'b1;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] fadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip(wa + wb);
  endfunction

  function automatic logic signed [63:0] fsub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clip(wa - wb);
  endfunction

  function automatic logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b,
                                              int sh);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    return clip(p >>> sh);
  endfunction

  function automatic logic [63:0] fdist(logic signed [63:0] a, logic signed [63:0] b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic [1:0] membership(logic signed [63:0] cre, logic signed [63:0] cim);
    logic signed [63:0] k115, k049, k2, k4, k1, k125, k075, k0625, k0375, k065, k025;
    logic signed [63:0] zre, zim, pre, pim, tre, tim, tpre, v, xp1, a, q, t;
    logic [23:0] i;
    k115 = kfx(115, 100); k049 = kfx(49, 100); k2 = kfx(2, 1); k4 = kfx(4, 1);
    k1 = kfx(1, 1); k125 = kfx(125, 100); k075 = kfx(75, 100);
    k0625 = kfx(625, 10000); k0375 = kfx(375, 1000); k065 = kfx(65, 100);
    k025 = kfx(25, 100);
    ovf = 1'b0;
    if (cim < -k115 || cim > k115 || cre < -k2 || cre > k049) return VERD_OUT;
    v = fadd(fmul(cre, cre, FB), fmul(cim, cim, FB));
    if (ovf || v > k4) return VERD_OUT;
    if (cre > -k125 && cre < -k075 && cim < k025) begin
      xp1 = fadd(cre, k1);
      v = fsub(fadd(fmul(xp1, xp1, FB), fmul(cim, cim, FB)), k0625);
      if (ovf) return VERD_OUT;
      if (v < 0) return VERD_IN;
    end else if (cre > -k075 && cre < k0375 && cim < k065) begin
      a = fsub(cre, k025);
      q = fadd(fmul(a, a, FB), fmul(cim, cim, FB));
      t = fadd(q, fmul(a, k025, FB - 1));
      v = fsub(fmul(t, t, FB), fmul(k025, q, FB));
      if (ovf) return VERD_OUT;
      if (v < 0) return VERD_IN;
    end
    zre = cre; zim = cim; tre = cre; tim = cim;
    for (i = 0; i < m_dwell; i++) begin
      pre = zre;
      pim = zim;
      zre = fadd(fsub(fmul(zre, zre, FB), fmul(zim, zim, FB)), cre);
      zim = fadd(fmul(pre, zim, FB - 1), cim);
      if (ovf) return VERD_OUT;
      if (i % 5 == 1) begin
        v = fadd(fmul(zre, zre, FB), fmul(zim, zim, FB));
        if (ovf || v > k4) return VERD_OUT;
        if (fdist(pre, zre) < {3'b0, m_settle} && fdist(pim, zim) < {3'b0, m_settle})
          return VERD_IN;
      end
      if (i[0]) begin
        tpre = tre;
        tre = fadd(fsub(fmul(tre, tre, FB), fmul(tim, tim, FB)), cre);
        tim = fadd(fmul(tpre, tim, FB - 1), cim);
        if (ovf) return VERD_OUT;
        if (fdist(tre, zre) < {3'b0, m_orbit} && fdist(tim, zim) < {3'b0, m_orbit})
          return VERD_IN;
      end
    end
    return VERD_UNDECIDED;
  endfunction

  function automatic logic signed [63:0] fx(real r);
    return longint'(r * 1152921504606846976.0);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom % 100;
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_point(logic signed [63:0] re, logic signed [63:0] im);
    int g;
    logic [1:0] v;
    push <= 1'b1;
    point_re <= re;
    point_im <= im;
    @(posedge clk);
    while (full) @(posedge clk);
    v = membership(re, im);
    verdict_q.push_back(v);
    n_items++;
    case (v)
      VERD_OUT: n_out++;
      VERD_IN:  n_in++;
      default:  n_und++;
    endcase
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DWELL:  m_dwell = data[23:0];
      CFG_SETTLE: m_settle = data[60:0];
      CFG_ORBIT:  m_orbit = data[60:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] dw, logic [63:0] st, logic [63:0] ob);
    drain();
    write_reg(CFG_DWELL, dw);
    write_reg(CFG_SETTLE, st);
    write_reg(CFG_ORBIT, ob);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [63:0] rnd_range(logic signed [63:0] lo,
                                                    logic signed [63:0] hi);
    longint unsigned span;
    span = 64'(hi - lo) + 1;
    return lo + 64'({$urandom, $urandom} % span);
  endfunction

  function automatic logic signed [63:0] edge_val();
    case ($urandom % 8)
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'd0;
      3: return -64'sd1;
      4: return kfx(115, 100);
      5: return -kfx(115, 100);
      6: return -kfx(2, 1);
      default: return kfx(49, 100);
    endcase
  endfunction

  task automatic random_point();
    int r;
    r = $urandom % 100;
    if (r < 15) send_point({$urandom, $urandom}, {$urandom, $urandom});
    else if (r < 25) send_point(edge_val(), edge_val());
    else send_point(rnd_range(-kfx(2, 1), kfx(49, 100)),
                    rnd_range(-kfx(115, 100), kfx(115, 100)));
  endtask

  // receiver side: random pop with short and long stalls, plus a forced long hold
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else if (stall_go) begin
      pop <= 1'b0;
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (no_idle) begin
      pop <= 1'b1;
    end else begin
      rx_roll = $urandom % 100;
      if (rx_roll < 3) begin
        pop <= 1'b0;
        hold_left <= $urandom_range(10, 80);
      end else begin
        pop <= (rx_roll >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict transaction, expected none, actual %0d",
                 $time, verdict);
        errors++;
      end else begin
        if (verdict !== verdict_q[0]) begin
          $display("%0t: verdict expected %0d, actual %0d", $time, verdict_q[0], verdict);
          errors++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  task automatic test_reset_values();
    send_point(fx(0.0), fx(0.0));
    send_point(fx(-1.0), fx(0.0));
    send_point(fx(0.4), fx(0.4));
    send_point(fx(-0.75), fx(0.1));
    send_point(fx(-0.1), fx(0.8));
  endtask

  task automatic test_directed();
    configure(64, 1153, 1153);
    send_point(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_point(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_point(-kfx(2, 1), 64'd0);
    send_point(-kfx(2, 1) - 1, 64'd0);
    send_point(kfx(49, 100), 64'd0);
    send_point(kfx(49, 100) + 1, 64'd0);
    send_point(64'd0, kfx(115, 100) + 1);
    send_point(-kfx(2, 1), kfx(115, 100));
    send_point(fx(-1.0), fx(-0.2));
    send_point(fx(-1.0), fx(0.3));
    send_point(fx(0.0), fx(-0.6));
    send_point(fx(0.2), fx(0.7));
    send_point(fx(0.3), fx(0.6));
    send_point(fx(-1.9), fx(0.0));
    send_point(fx(-1.3), fx(0.05));
    send_point(fx(0.4), fx(0.4));
    send_point(fx(-0.1), fx(0.8));
    send_point(fx(-0.75), fx(0.2));
  endtask

  task automatic test_register_extremes();
    configure(64'hFF00_0000_0000_0010, 64'hE000_0000_0000_0000, 64'h1000_0000_0000_0000);
    send_point(fx(-0.1), fx(0.8));
    send_point(fx(-1.9), fx(0.0));
    configure(0, 0, 0);
    send_point(fx(-0.1), fx(0.8));
    send_point(fx(0.0), fx(0.0));
    send_point(fx(1.0), fx(0.0));
    drain();
    write_reg(CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_valid <= 1'b0;
    configure(24'hFF_FFFF, 64'h1000_0000_0000_0000, 64'h1000_0000_0000_0000);
    send_point(fx(0.0), fx(0.0));
    send_point(fx(0.4), fx(0.4));
    send_point(fx(-0.1), fx(0.8));
    configure(1, 1153, 1153);
    send_point(fx(-0.1), fx(0.8));
  endtask

  task automatic test_random();
    logic [63:0] dw, st, ob;
    for (int seg = 0; seg < 9; seg++) begin
      case ($urandom % 4)
        0: dw = $urandom_range(1, 3);
        default: dw = $urandom_range(4, 40);
      endcase
      case ($urandom % 4)
        0: st = 0;
        1: st = 64'h1000_0000_0000_0000;
        2: st = 1153;
        default: st = {$urandom, $urandom} % (64'd1 << 50);
      endcase
      case ($urandom % 4)
        0: ob = 0;
        1: ob = 64'h1000_0000_0000_0000;
        2: ob = 1153;
        default: ob = {$urandom, $urandom} % (64'd1 << 50);
      endcase
      configure(dw, st, ob);
      no_idle = (seg == 4);
      repeat (60) random_point();
      no_idle = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    configure(8, 1153, 1153);
    stall_go <= 1'b1;
    @(posedge clk);
    stall_go <= 1'b0;
    no_idle = 1'b1;
    repeat (12) random_point();
    no_idle = 1'b0;
    drain();
    repeat (6) random_point();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_register_extremes();
    test_random();
    test_backpressure();
    push <= 1'b0;
    while (verdict_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d points sent: %0d rejected or escaped, %0d members, %0d undecided",
             n_items, n_out, n_in, n_und);
    $display("register extremes, zero dwell, random settings and a long result stall covered");
    if (errors == 0)
      $display("mandelbrot_membership_test: match");
    else
      $display("mandelbrot_membership_test: mismatch");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("mandelbrot_membership_test: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/mbm_pkg.sv
src/mbm_front.sv
src/mbm_fifo.sv
src/mbm_mul.sv
src/mbm_back.sv
src/mandelbrot_membership_test.sv
src/mbm_checker.sv
tb/testbench.sv
